@@ rtl/ps2mct_pkg.sv @@
// Shared types, constants and the seven-segment decode for the PS/2 cursor tracker.
package ps2mct_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned POS_W   = 10;
   localparam int unsigned DIGITS  = 6;
   localparam int unsigned SEG_W   = 8;
   localparam int unsigned HEX_W   = DIGITS * SEG_W;
   localparam int unsigned CNT_W   = 2;

   localparam logic [BYTE_W-1:0] SELF_TEST_PASS = 8'hAA;
   localparam logic [BYTE_W-1:0] SELF_TEST_ID   = 8'h00;

   localparam logic [POS_W-1:0] MAX_X_RESET = 10'd315;
   localparam logic [POS_W-1:0] MAX_Y_RESET = 10'd235;

   localparam logic [CNT_W-1:0] CNT_REALIGN = 2'd1;
   localparam logic [CNT_W-1:0] CNT_DONE    = 2'd3;

   typedef enum logic {
      REG_MAX_X = 1'b0,
      REG_MAX_Y = 1'b1
   } reg_sel_type;

   typedef struct packed {
      logic [HEX_W-1:0] hex_segments;
      logic [POS_W-1:0] cursor_y;
      logic [POS_W-1:0] cursor_x;
      logic             packet_done;
      logic             send_enable;
   } rsp_type;

   function automatic logic [SEG_W-1:0] seg_decode(input logic [3:0] nibble);
      logic [SEG_W-1:0] code;
      case (nibble)
         4'h0: code = 8'h3F;
         4'h1: code = 8'h06;
         4'h2: code = 8'h5B;
         4'h3: code = 8'h4F;
         4'h4: code = 8'h66;
         4'h5: code = 8'h6D;
         4'h6: code = 8'h7D;
         4'h7: code = 8'h07;
         4'h8: code = 8'h7F;
         4'h9: code = 8'h67;
         4'hA: code = 8'h77;
         4'hB: code = 8'h7C;
         4'hC: code = 8'h39;
         4'hD: code = 8'h5E;
         4'hE: code = 8'h79;
         default: code = 8'h71;
      endcase
      return code;
   endfunction

endpackage

@@ rtl/ps2mct_seg.sv @@
// Seven-segment patterns for the six hex digits of the three most recent bytes.
module ps2mct_seg (
   input  logic [3*ps2mct_pkg::BYTE_W-1:0] word,
   output logic [ps2mct_pkg::HEX_W-1:0]    segments
);

   for (genvar k = 0; k < ps2mct_pkg::DIGITS; k++) begin : g_digit
      assign segments[k*ps2mct_pkg::SEG_W +: ps2mct_pkg::SEG_W] =
         ps2mct_pkg::seg_decode(word[4*k +: 4]);
   end

endmodule

@@ rtl/ps2_mouse_cursor_tracker.sv @@
// PS/2 mouse cursor tracker: byte history, packet alignment, clamped cursor and display codes.
//
// Each accepted byte produces one result in the result register; a new byte can be taken every
// cycle as long as the result register is empty or being drained in the same cycle, so
// the rate is one byte per clock, set only by the single result register and rsp_tready.
// Results carry the hex display codes of the three latest bytes, the cursor position
// (updated on every third byte of a packet, clamped to 0..max_x / 0..max_y), packet_done
// on rsp_tlast, and send_enable when the self-test sequence AA 00 is seen, which also
// realigns packet counting so that the next byte closes a packet. max_x and max_y are written
// through the csr port at byte addresses 0 and 4, by the user only while the block is idle
// (the block does not enforce this); a lowered limit takes effect at the next packet end.
module ps2_mouse_cursor_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,    // [0] send_enable, [10:1] cursor_x, [20:11] cursor_y,
                                     // [68:21] hex_segments, [71:69] zero
   output logic        rsp_tlast,    // packet_done
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned BW = ps2mct_pkg::BYTE_W;
   localparam int unsigned PW = ps2mct_pkg::POS_W;
   localparam int unsigned CW = ps2mct_pkg::CNT_W;
   localparam int unsigned SW = PW + 2;

   logic [PW-1:0] max_x_ff, max_x_in;
   logic [PW-1:0] max_y_ff, max_y_in;
   logic [BW-1:0] older_byte_ff, older_byte_in;
   logic [BW-1:0] newer_byte_ff, newer_byte_in;
   logic [CW-1:0] byte_count_ff, byte_count_in;
   logic [PW-1:0] pos_x_ff, pos_x_in;
   logic [PW-1:0] pos_y_ff, pos_y_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ps2mct_pkg::rsp_type rsp_ff, rsp_in;

   logic                    req_accept;
   logic                    csr_write;
   ps2mct_pkg::reg_sel_type csr_sel;
   logic [BW-1:0]           rx_byte;
   logic                    self_test;
   logic [CW-1:0]           cnt_base;
   logic [CW-1:0]           cnt_next;
   logic                    done;
   logic signed [BW:0]      dx_adj;
   logic signed [BW:0]      dy_adj;
   logic signed [BW-1:0]    dx;
   logic signed [BW-1:0]    dy;
   logic signed [SW-1:0]    sum_x;
   logic signed [SW-1:0]    sum_y;
   logic [ps2mct_pkg::HEX_W-1:0] segments;

   assign csr_pready = 1'b1;
   assign csr_sel    = ps2mct_pkg::reg_sel_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_sel)
         ps2mct_pkg::REG_MAX_X: csr_prdata = {{(32-PW){1'b0}}, max_x_ff};
         ps2mct_pkg::REG_MAX_Y: csr_prdata = {{(32-PW){1'b0}}, max_y_ff};
         default:               csr_prdata = '0;
      endcase
   end

   always_comb begin
      max_x_in = max_x_ff;
      max_y_in = max_y_ff;
      if (csr_write) begin
         unique case (csr_sel)
            ps2mct_pkg::REG_MAX_X: max_x_in = csr_pwdata[PW-1:0];
            ps2mct_pkg::REG_MAX_Y: max_y_in = csr_pwdata[PW-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign rx_byte    = req_tdata;

   ps2mct_seg u_seg (
      .word     ({older_byte_ff, newer_byte_ff, rx_byte}),
      .segments (segments)
   );

   assign self_test = (newer_byte_ff == ps2mct_pkg::SELF_TEST_PASS) &&
                      (rx_byte == ps2mct_pkg::SELF_TEST_ID);
   assign cnt_base  = self_test ? ps2mct_pkg::CNT_REALIGN : byte_count_ff;
   assign cnt_next  = cnt_base + CW'(1);
   assign done      = (cnt_next == ps2mct_pkg::CNT_DONE);

   // halve toward zero: bias negatives by one before the arithmetic shift
   assign dx_adj = $signed({newer_byte_ff[BW-1], newer_byte_ff}) +
                   $signed({{BW{1'b0}}, newer_byte_ff[BW-1]});
   assign dy_adj = $signed({rx_byte[BW-1], rx_byte}) +
                   $signed({{BW{1'b0}}, rx_byte[BW-1]});
   assign dx     = dx_adj[BW:1];
   assign dy     = dy_adj[BW:1];

   assign sum_x = $signed({2'b00, pos_x_ff}) + SW'(dx);
   assign sum_y = $signed({2'b00, pos_y_ff}) - SW'(dy);

   always_comb begin
      older_byte_in = older_byte_ff;
      newer_byte_in = newer_byte_ff;
      byte_count_in = byte_count_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      if (req_accept) begin
         older_byte_in = newer_byte_ff;
         newer_byte_in = rx_byte;
         byte_count_in = done ? '0 : cnt_next;
         if (done) begin
            if (sum_x > $signed({2'b00, max_x_ff})) begin
               pos_x_in = max_x_ff;
            end else if (sum_x < 0) begin
               pos_x_in = '0;
            end else begin
               pos_x_in = sum_x[PW-1:0];
            end
            if (sum_y > $signed({2'b00, max_y_ff})) begin
               pos_y_in = max_y_ff;
            end else if (sum_y < 0) begin
               pos_y_in = '0;
            end else begin
               pos_y_in = sum_y[PW-1:0];
            end
         end
         rsp_in.send_enable  = self_test;
         rsp_in.packet_done  = done;
         rsp_in.cursor_x     = pos_x_in;
         rsp_in.cursor_y     = pos_y_in;
         rsp_in.hex_segments = segments;
         rsp_valid_in        = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_x_ff      <= ps2mct_pkg::MAX_X_RESET;
         max_y_ff      <= ps2mct_pkg::MAX_Y_RESET;
         older_byte_ff <= '0;
         newer_byte_ff <= '0;
         byte_count_ff <= '0;
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         max_x_ff      <= max_x_in;
         max_y_ff      <= max_y_in;
         older_byte_ff <= older_byte_in;
         newer_byte_ff <= newer_byte_in;
         byte_count_ff <= byte_count_in;
         pos_x_ff      <= pos_x_in;
         pos_y_ff      <= pos_y_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.packet_done;
   assign rsp_tdata  = {3'b000, rsp_ff.hex_segments, rsp_ff.cursor_y, rsp_ff.cursor_x,
                        rsp_ff.send_enable};

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff != ps2mct_pkg::CNT_DONE)
      else $error("packet counter reached its terminal value");

   a_enable_not_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.send_enable) |-> !rsp_ff.packet_done)
      else $error("self-test transaction closed a packet");

   a_accept_valid: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (rsp_valid_ff && rsp_ff.cursor_x == pos_x_ff &&
                      rsp_ff.cursor_y == pos_y_ff))
      else $error("result missing or cursor out of step after transaction");

   a_clamp_x: assert property (@(posedge clock) disable iff (reset)
      (req_accept && done) |=> (pos_x_ff <= $past(max_x_ff) && pos_y_ff <= $past(max_y_ff)))
      else $error("cursor above limit after packet");

endmodule

@@ tb/sv/tb_ps2_mouse_cursor_tracker.sv @@
// Self-checking testbench for the PS/2 mouse cursor tracker: stream stimulus, APB limits, scoreboard.
`timescale 1ns / 100ps

class cursor_tracker_model;
   bit   [ps2mct_pkg::SEG_W-1:0]  seg_lut [16];
   logic [ps2mct_pkg::POS_W-1:0]  lim_x;
   logic [ps2mct_pkg::POS_W-1:0]  lim_y;
   logic [ps2mct_pkg::BYTE_W-1:0] older;
   logic [ps2mct_pkg::BYTE_W-1:0] newer;
   logic [ps2mct_pkg::CNT_W-1:0]  count;
   logic [ps2mct_pkg::POS_W-1:0]  pos_x;
   logic [ps2mct_pkg::POS_W-1:0]  pos_y;
   ps2mct_pkg::rsp_type           pending_reports [$];
   int                            errors;

   function new();
      seg_lut = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
                  8'h7F, 8'h67, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71};
      lim_x  = ps2mct_pkg::MAX_X_RESET;
      lim_y  = ps2mct_pkg::MAX_Y_RESET;
      older  = '0;
      newer  = '0;
      count  = '0;
      pos_x  = '0;
      pos_y  = '0;
      errors = 0;
   endfunction

   function void set_limit(ps2mct_pkg::reg_sel_type sel, logic [ps2mct_pkg::POS_W-1:0] value);
      if (sel == ps2mct_pkg::REG_MAX_X) begin
         lim_x = value;
      end else begin
         lim_y = value;
      end
   endfunction

   function int half_toward_zero(logic [ps2mct_pkg::BYTE_W-1:0] b);
      int v;
      v = int'($signed(b));
      return v / 2;
   endfunction

   function int fit(int v, logic [ps2mct_pkg::POS_W-1:0] hi);
      if (v > int'(hi)) v = int'(hi);
      if (v < 0) v = 0;
      return v;
   endfunction

   function void note_byte(logic [ps2mct_pkg::BYTE_W-1:0] rx);
      logic [ps2mct_pkg::BYTE_W-1:0] b1;
      logic [ps2mct_pkg::BYTE_W-1:0] b2;
      logic [23:0]                   word;
      ps2mct_pkg::rsp_type           e;
      b1    = older;
      b2    = newer;
      older = newer;
      newer = rx;
      word  = {b1, b2, rx};
      e     = '0;
      for (int k = 0; k < ps2mct_pkg::DIGITS; k++) begin
         e.hex_segments[ps2mct_pkg::SEG_W*k +: ps2mct_pkg::SEG_W] = seg_lut[word[4*k +: 4]];
      end
      if (b2 == ps2mct_pkg::SELF_TEST_PASS && rx == ps2mct_pkg::SELF_TEST_ID) begin
         e.send_enable = 1'b1;
         count = ps2mct_pkg::CNT_REALIGN;
      end
      count = count + 2'd1;
      if (count == ps2mct_pkg::CNT_DONE) begin
         count = '0;
         e.packet_done = 1'b1;
         pos_x = ps2mct_pkg::POS_W'(fit(int'(pos_x) + half_toward_zero(b2), lim_x));
         pos_y = ps2mct_pkg::POS_W'(fit(int'(pos_y) - half_toward_zero(rx), lim_y));
      end
      e.cursor_x = pos_x;
      e.cursor_y = pos_y;
      pending_reports.push_back(e);
   endfunction

   task report(string what, logic [63:0] want, logic [63:0] got);
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
      errors++;
   endtask

   task check_report(logic [71:0] data, logic last);
      ps2mct_pkg::rsp_type e;
      if (pending_reports.size() == 0) begin
         report("unexpected transaction", 64'd0, data[63:0]);
         return;
      end
      e = pending_reports.pop_front();
      if (data[0] !== e.send_enable) report("send_enable", e.send_enable, data[0]);
      if (last !== e.packet_done) report("packet_done", e.packet_done, last);
      if (data[10:1] !== e.cursor_x) report("cursor_x", e.cursor_x, data[10:1]);
      if (data[20:11] !== e.cursor_y) report("cursor_y", e.cursor_y, data[20:11]);
      if (data[68:21] !== e.hex_segments) report("hex_segments", e.hex_segments, data[68:21]);
      if (data[71:69] !== 3'b000) report("tdata padding", 64'd0, data[71:69]);
   endtask
endclass

module tb_ps2_mouse_cursor_tracker;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_ITEMS  = 300;
   localparam int PHASES       = 6;
   localparam int HOLD_CYCLES  = 400;
   localparam int FLAG_ONE_BIT = 3;

   logic        clock;
   logic        reset        = 1'b1;
   logic        req_tvalid   = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata    = '0;    // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready   = 1'b0;
   logic [71:0] rsp_tdata;            // [0] send_enable, [10:1] cursor_x, [20:11] cursor_y,
                                      // [68:21] hex_segments, [71:69] zero
   logic        rsp_tlast;            // packet_done
   logic        csr_psel     = 1'b0;
   logic        csr_penable  = 1'b0;
   logic        csr_pwrite   = 1'b0;
   logic [2:0]  csr_paddr    = '0;
   logic [31:0] csr_pwdata   = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   cursor_tracker_model tracker;
   int                  items_sent       = 0;
   int                  rsp_hold_request = 0;
   bit                  sender_calm      = 1'b0;

   ps2_mouse_cursor_tracker u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [7:0] pick_motion();
      if ($urandom_range(0, 9) != 0) return 8'($urandom);
      case ($urandom_range(0, 5))
         0: return 8'h00;
         1: return 8'h7F;
         2: return 8'h80;
         3: return 8'hFF;
         4: return 8'h01;
         default: return 8'h81;
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = sender_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      tracker.note_byte(b);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input ps2mct_pkg::reg_sel_type sel,
                            input logic [ps2mct_pkg::POS_W-1:0] value);
      logic [31:0] word;
      word       = $urandom;
      word[9:0]  = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tracker.set_limit(sel, value);
      @(posedge clock);
   endtask

   task automatic csr_read_check(input ps2mct_pkg::reg_sel_type sel);
      logic [ps2mct_pkg::POS_W-1:0] want;
      want = (sel == ps2mct_pkg::REG_MAX_X) ? tracker.lim_x : tracker.lim_y;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {sel, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[9:0] !== want) tracker.report("csr readback", want, csr_prdata[9:0]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_limits(input logic [ps2mct_pkg::POS_W-1:0] x,
                             input logic [ps2mct_pkg::POS_W-1:0] y);
      wait_drained();
      repeat (4) @(posedge clock);
      csr_write(ps2mct_pkg::REG_MAX_X, x);
      csr_write(ps2mct_pkg::REG_MAX_Y, y);
      csr_read_check(ps2mct_pkg::REG_MAX_X);
      csr_read_check(ps2mct_pkg::REG_MAX_Y);
   endtask

   task automatic run_random(input int n);
      int          target;
      int          r;
      logic [7:0]  flag;
      target = items_sent + n;
      while (items_sent < target) begin
         r = $urandom_range(0, 99);
         if (r < 80) begin
            flag = 8'($urandom);
            if ($urandom_range(0, 7) != 0) flag[FLAG_ONE_BIT] = 1'b1;
            send_byte(flag);
            send_byte(pick_motion());
            send_byte(pick_motion());
         end else if (r < 88) begin
            send_byte(ps2mct_pkg::SELF_TEST_PASS);
            send_byte(ps2mct_pkg::SELF_TEST_ID);
         end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
         end
      end
   endtask

   initial begin : rsp_side
      int stall_left;
      int calm_left;
      int r;
      stall_left = 0;
      calm_left  = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) tracker.check_report(rsp_tdata, rsp_tlast);
         if (rsp_hold_request > 0) begin
            stall_left       = rsp_hold_request;
            rsp_hold_request = 0;
            calm_left        = 0;
         end
         if (stall_left == 0 && calm_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 8) calm_left = $urandom_range(20, 200);
            else if (r < 30) stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (calm_left > 0) calm_left--;
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : main_seq
      logic [7:0] opening [];
      opening = '{8'h08, 8'h7F, 8'h80,
                  8'h08, 8'hFF, 8'h01,
                  8'h08, 8'h81, 8'h7F,
                  8'h18, 8'h80, 8'h81,
                  8'hAA, 8'h00, 8'h7E,
                  8'h08, 8'hAA, 8'h00, 8'h40,
                  8'hFF, 8'h00, 8'h00};
      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset limits first, then push x and y against tight limits
      foreach (opening[i]) send_byte(opening[i]);
      set_limits(10'd40, 10'd30);
      repeat (2) begin
         send_byte(8'h08);
         send_byte(8'h7F);
         send_byte(8'h80);
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: set_limits(10'd1023, 10'd1023);
            1: set_limits(10'd0, 10'd0);
            3: set_limits(10'd17, 10'd900);
            4: set_limits(ps2mct_pkg::MAX_X_RESET, ps2mct_pkg::MAX_Y_RESET);
            default: set_limits(ps2mct_pkg::POS_W'($urandom), ps2mct_pkg::POS_W'($urandom));
         endcase
         sender_calm = (p == 2);
         if (p == 1) begin
            // hold the result side and keep offering back to back
            rsp_hold_request = HOLD_CYCLES;
            sender_calm      = 1'b1;
            run_random(60);
            sender_calm      = 1'b0;
            wait_drained();
         end
         run_random(PHASE_ITEMS);
      end

      wait_drained();
      repeat (5) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_reports.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
